// File: sv/read_quality_stats_accumulator_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef READ_QUALITY_STATS_ACCUMULATOR_UNIT_DEFINES_SVH
`define READ_QUALITY_STATS_ACCUMULATOR_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define RQSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rqsa assertion failed");

// Checks a property on every clock edge, reset included.
`define RQSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("rqsa assertion failed");

`endif

// File: sv/rqsa_pkg.sv
package rqsa_pkg;

  // Store geometry.
  localparam int unsigned MaxReadLen = 256;
  localparam int unsigned QualBins   = 100;
  localparam int unsigned NumBases   = 5;
  localparam int unsigned NumTotals  = 6;

  localparam int unsigned PbcDepth = NumBases * MaxReadLen;
  localparam int unsigned LenDepth = MaxReadLen + 1;

  localparam int unsigned PbcAw  = 11;
  localparam int unsigned PosAw  = 8;
  localparam int unsigned HistAw = 7;
  localparam int unsigned LenAw  = 9;
  localparam int unsigned TotAw  = 3;

  // Readout table selectors.
  localparam logic [2:0] TblBaseCnt = 3'd0;
  localparam logic [2:0] TblFwdQsum = 3'd1;
  localparam logic [2:0] TblRevQsum = 3'd2;
  localparam logic [2:0] TblBaseQh  = 3'd3;
  localparam logic [2:0] TblReadQh  = 3'd4;
  localparam logic [2:0] TblTotals  = 3'd5;
  localparam logic [2:0] TblLenHist = 3'd6;

  // Scalar total indexes.
  localparam logic [2:0] TotFwdReads = 3'd0;
  localparam logic [2:0] TotRevReads = 3'd1;
  localparam logic [2:0] TotBases    = 3'd2;
  localparam logic [2:0] TotQ20Bases = 3'd3;
  localparam logic [2:0] TotQ30Bases = 3'd4;
  localparam logic [2:0] TotQ20Reads = 3'd5;

  // Error codes.
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrQual  = 2'd1;
  localparam logic [1:0] ErrRange = 2'd2;

  localparam logic [2:0] BaseN = 3'd4;

endpackage

// File: sv/rqsa_if.sv
// Base input channel.
interface rqsa_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] base_code;
  logic [6:0] quality;
  logic       is_reverse;
  logic       last_base;
  logic       skip_read;
  logic [2:0] table_sel;
  logic [8:0] index;

  modport source (output valid, func, base_code, quality, is_reverse, last_base,
                  skip_read, table_sel, index, input ready);
  modport sink (input valid, func, base_code, quality, is_reverse, last_base,
                skip_read, table_sel, index, output ready);
endinterface

// Result channel.
interface rqsa_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] value;
  logic [1:0]  error;
  logic        read_done;
  logic [6:0]  read_mean_quality;

  modport source (output valid, value, error, read_done, read_mean_quality,
                  input ready);
  modport sink (input valid, value, error, read_done, read_mean_quality,
                output ready);
endinterface

// Configuration write channel.
interface rqsa_cfg_if;
  logic valid;
  logic ready;
  logic long_read_mode;

  modport source (output valid, long_read_mode, input ready);
  modport sink (input valid, long_read_mode, output ready);
endinterface

// File: sv/rqsa_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module rqsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/read_quality_stats_accumulator_unit.sv
// Channel | Dir | Word
// in_i    | in  | func, base_code, quality, is_reverse, last_base, skip_read, table_sel, index
// out_o   | out | value, error, read_done, read_mean_quality
// cfg_i   | in  | long_read_mode
//
// A readout or a base that does not close a read first reads the counter memories,
// then returns the value or modifies and writes back the counters. A base that closes
// a read then runs the serial mean divider and a histogram read and write-back.
// After reset a clearing pass zeroes the memories; no base is taken during it. A
// stalled result waits in the output register while the next word is taken.
module read_quality_stats_accumulator_unit (
  input logic       clk_i,
  input logic       rst_ni,
  rqsa_in_if.sink   in_i,
  rqsa_out_if.source out_o,
  rqsa_cfg_if.sink  cfg_i
);
  import rqsa_pkg::*;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StCrd  = 3'd4;
  localparam logic [2:0] StCwr  = 3'd5;
  localparam logic [2:0] StPush = 3'd6;

  logic [2:0] state_q, state_d;
  logic [PbcAw-1:0] clr_cnt_q;
  logic lrm_q;

  // Latched word.
  logic       func_q, rev_q, last_q, skip_q;
  logic [2:0] base_q, sel_q;
  logic [6:0] qual_q;
  logic [8:0] idx_q;

  // Open read.
  logic [8:0]  pos_q;
  logic [14:0] qsum_q;

  // Closing read.
  logic [8:0]  len_q;
  logic [6:0]  mean_q;
  logic        close_fwd_q, q20r_q;
  logic [1:0]  close_err_q;
  logic [15:0] dvd_q, quo_q;
  logic [9:0]  rem_q;
  logic [3:0]  div_cnt_q;

  logic [47:0] tot_q [NumTotals];

  // Pending and output result.
  logic [47:0] pend_value_q, out_value_q;
  logic [1:0]  pend_err_q, out_err_q;
  logic        pend_done_q, out_done_q;
  logic [6:0]  pend_mean_q, out_mean_q;
  logic        out_valid_q;

  // Configuration register.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrm_q <= 1'b0;
    end else if (cfg_i.valid) begin
      lrm_q <= cfg_i.long_read_mode;
    end
  end

  logic in_acc;
  assign in_i.ready = (state_q == StIdle);
  assign in_acc = in_i.valid && in_i.ready;

  // Address sources: the live word while idle, the latched word after.
  logic       a_func;
  logic [2:0] a_base, a_bnorm;
  logic [6:0] a_qual;
  logic [8:0] a_idx;
  always_comb begin
    if (state_q == StIdle) begin
      a_func = in_i.func;
      a_base = in_i.base_code;
      a_qual = in_i.quality;
      a_idx  = in_i.index;
    end else begin
      a_func = func_q;
      a_base = base_q;
      a_qual = qual_q;
      a_idx  = idx_q;
    end
    a_bnorm = (a_base > BaseN) ? BaseN : a_base;
  end

  logic [PbcAw-1:0]  pbc_addr;
  logic [PosAw-1:0]  pos_addr;
  logic [HistAw-1:0] bqh_addr, rqh_addr;
  logic [LenAw-1:0]  rlh_addr;
  always_comb begin
    pbc_addr = a_func ? {a_base, a_idx[PosAw-1:0]} : {a_bnorm, pos_q[PosAw-1:0]};
    pos_addr = a_func ? a_idx[PosAw-1:0] : pos_q[PosAw-1:0];
    bqh_addr = a_func ? a_idx[HistAw-1:0] : a_qual;
    rqh_addr = (state_q == StCrd || state_q == StCwr) ? mean_q : a_idx[HistAw-1:0];
    rlh_addr = (state_q == StCrd || state_q == StCwr) ? len_q : a_idx;
  end

  // Memory write control.
  logic        clearing;
  logic        pbc_we, fqs_we, rqs_we, bqh_we, rqh_we, rlh_we;
  logic [31:0] pbc_wd, rqh_wd, rlh_wd;
  logic [39:0] fqs_wd, rqs_wd;
  logic [47:0] bqh_wd;
  logic [31:0] pbc_rd, rqh_rd, rlh_rd;
  logic [39:0] fqs_rd, rqs_rd;
  logic [47:0] bqh_rd;

  logic acc_go, qbad, in_range, fwd;
  assign clearing = (state_q == StClr);
  assign fwd      = lrm_q || !rev_q;
  assign acc_go   = (state_q == StExec) && !func_q && !skip_q;
  assign qbad     = (qual_q >= 7'(QualBins));
  assign in_range = (pos_q < 9'(MaxReadLen));

  always_comb begin
    pbc_we = clearing ? (clr_cnt_q < PbcAw'(PbcDepth)) : (acc_go && !qbad && in_range);
    fqs_we = clearing ? (clr_cnt_q < PbcAw'(MaxReadLen))
                      : (acc_go && !qbad && in_range && fwd);
    rqs_we = clearing ? (clr_cnt_q < PbcAw'(MaxReadLen))
                      : (acc_go && !qbad && in_range && !fwd);
    bqh_we = clearing ? (clr_cnt_q < PbcAw'(QualBins)) : (acc_go && !qbad);
    rqh_we = clearing ? (clr_cnt_q < PbcAw'(QualBins)) : (state_q == StCwr);
    rlh_we = clearing ? (clr_cnt_q < PbcAw'(LenDepth)) : (state_q == StCwr);
    pbc_wd = clearing ? '0 : pbc_rd + 32'd1;
    fqs_wd = clearing ? '0 : fqs_rd + {33'd0, qual_q};
    rqs_wd = clearing ? '0 : rqs_rd + {33'd0, qual_q};
    bqh_wd = clearing ? '0 : bqh_rd + 48'd1;
    rqh_wd = clearing ? '0 : rqh_rd + 32'd1;
    rlh_wd = clearing ? '0 : rlh_rd + 32'd1;
  end

  rqsa_ram #(.Width(32), .Depth(PbcDepth)) u_pbc (
    .clk_i, .we_i(pbc_we), .waddr_i(clearing ? clr_cnt_q : pbc_addr),
    .wdata_i(pbc_wd), .raddr_i(pbc_addr), .rdata_o(pbc_rd)
  );
  rqsa_ram #(.Width(40), .Depth(MaxReadLen)) u_fqs (
    .clk_i, .we_i(fqs_we), .waddr_i(clearing ? clr_cnt_q[PosAw-1:0] : pos_addr),
    .wdata_i(fqs_wd), .raddr_i(pos_addr), .rdata_o(fqs_rd)
  );
  rqsa_ram #(.Width(40), .Depth(MaxReadLen)) u_rqs (
    .clk_i, .we_i(rqs_we), .waddr_i(clearing ? clr_cnt_q[PosAw-1:0] : pos_addr),
    .wdata_i(rqs_wd), .raddr_i(pos_addr), .rdata_o(rqs_rd)
  );
  rqsa_ram #(.Width(48), .Depth(QualBins)) u_bqh (
    .clk_i, .we_i(bqh_we), .waddr_i(clearing ? clr_cnt_q[HistAw-1:0] : bqh_addr),
    .wdata_i(bqh_wd), .raddr_i(bqh_addr), .rdata_o(bqh_rd)
  );
  rqsa_ram #(.Width(32), .Depth(QualBins)) u_rqh (
    .clk_i, .we_i(rqh_we), .waddr_i(clearing ? clr_cnt_q[HistAw-1:0] : rqh_addr),
    .wdata_i(rqh_wd), .raddr_i(rqh_addr), .rdata_o(rqh_rd)
  );
  rqsa_ram #(.Width(32), .Depth(LenDepth)) u_rlh (
    .clk_i, .we_i(rlh_we), .waddr_i(clearing ? clr_cnt_q[LenAw-1:0] : rlh_addr),
    .wdata_i(rlh_wd), .raddr_i(rlh_addr), .rdata_o(rlh_rd)
  );

  // Readout selection.
  logic [47:0] rd_value;
  logic        rd_bad;
  always_comb begin
    rd_value = '0;
    rd_bad   = 1'b0;
    case (sel_q)
      TblBaseCnt: begin
        rd_bad   = (base_q > BaseN) || (idx_q >= 9'(MaxReadLen));
        rd_value = {16'd0, pbc_rd};
      end
      TblFwdQsum: begin
        rd_bad   = (idx_q >= 9'(MaxReadLen));
        rd_value = {8'd0, fqs_rd};
      end
      TblRevQsum: begin
        rd_bad   = (idx_q >= 9'(MaxReadLen));
        rd_value = {8'd0, rqs_rd};
      end
      TblBaseQh: begin
        rd_bad   = (idx_q >= 9'(QualBins));
        rd_value = bqh_rd;
      end
      TblReadQh: begin
        rd_bad   = (idx_q >= 9'(QualBins));
        rd_value = {16'd0, rqh_rd};
      end
      TblTotals: begin
        rd_bad   = (idx_q >= 9'(NumTotals));
        rd_value = rd_bad ? '0 : tot_q[idx_q[TotAw-1:0]];
      end
      TblLenHist: begin
        rd_bad   = (idx_q > 9'(MaxReadLen));
        rd_value = {16'd0, rlh_rd};
      end
      default: rd_bad = 1'b1;
    endcase
    if (rd_bad) begin
      rd_value = '0;
    end
  end

  // Accumulate step: new position and sum of the open read.
  logic [8:0]  new_pos;
  logic [14:0] new_sum;
  logic [1:0]  acc_err;
  logic        closes;
  logic [13:0] len20;
  always_comb begin
    new_pos = pos_q;
    new_sum = qsum_q;
    acc_err = ErrNone;
    if (qbad) begin
      acc_err = ErrQual;
    end else if (in_range) begin
      new_pos = pos_q + 9'd1;
      new_sum = qsum_q + {8'd0, qual_q};
    end else begin
      acc_err = ErrRange;
    end
    closes = last_q && (new_pos != 9'd0);
    len20  = {1'b0, new_pos, 4'd0} + {3'd0, new_pos, 2'd0};
  end

  // Serial divider step for the rounded mean.
  logic [10:0] trial;
  logic        take;
  logic [9:0]  divisor;
  assign divisor = {len_q, 1'b0};
  assign trial   = {rem_q, dvd_q[15]};
  assign take    = (trial >= {1'b0, divisor});

  // Completion of the current word.
  logic        fin;
  logic [47:0] fin_value;
  logic [1:0]  fin_err;
  logic        fin_done;
  logic [6:0]  fin_mean;
  logic        out_free;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    fin       = 1'b0;
    fin_value = '0;
    fin_err   = ErrNone;
    fin_done  = 1'b0;
    fin_mean  = '0;
    state_d   = state_q;
    case (state_q)
      StClr: begin
        if (clr_cnt_q == PbcAw'(PbcDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (func_q) begin
          fin       = 1'b1;
          fin_value = rd_value;
          fin_err   = rd_bad ? ErrRange : ErrNone;
        end else if (skip_q) begin
          fin = 1'b1;
        end else if (closes) begin
          state_d = StDiv;
        end else begin
          fin     = 1'b1;
          fin_err = acc_err;
        end
      end
      StDiv: begin
        if (div_cnt_q == 4'd15) begin
          state_d = StCrd;
        end
      end
      StCrd: state_d = StCwr;
      StCwr: begin
        fin      = 1'b1;
        fin_err  = close_err_q;
        fin_done = 1'b1;
        fin_mean = mean_q;
      end
      StPush: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (fin) begin
      state_d = out_free ? StIdle : StPush;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClr;
      clr_cnt_q <= '0;
      pos_q     <= '0;
      qsum_q    <= '0;
      div_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + PbcAw'(1);
      end
      if (acc_go) begin
        pos_q  <= closes ? 9'd0 : new_pos;
        qsum_q <= closes ? 15'd0 : new_sum;
      end
      if (state_q == StDiv) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end else begin
        div_cnt_q <= '0;
      end
      if (fin && out_free) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == StPush) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scalar totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTotals; i++) begin
        tot_q[i] <= '0;
      end
    end else begin
      if (acc_go && !qbad) begin
        tot_q[TotBases] <= tot_q[TotBases] + 48'd1;
        if (qual_q >= 7'd20) begin
          tot_q[TotQ20Bases] <= tot_q[TotQ20Bases] + 48'd1;
        end
        if (qual_q >= 7'd30) begin
          tot_q[TotQ30Bases] <= tot_q[TotQ30Bases] + 48'd1;
        end
      end
      if (state_q == StCwr) begin
        if (close_fwd_q) begin
          tot_q[TotFwdReads] <= tot_q[TotFwdReads] + 48'd1;
        end else begin
          tot_q[TotRevReads] <= tot_q[TotRevReads] + 48'd1;
        end
        if (q20r_q) begin
          tot_q[TotQ20Reads] <= tot_q[TotQ20Reads] + 48'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_i.func;
      base_q <= in_i.base_code;
      qual_q <= in_i.quality;
      rev_q  <= in_i.is_reverse;
      last_q <= in_i.last_base;
      skip_q <= in_i.skip_read;
      sel_q  <= in_i.table_sel;
      idx_q  <= in_i.index;
    end
    if (acc_go && closes) begin
      len_q       <= new_pos;
      close_fwd_q <= fwd;
      close_err_q <= acc_err;
      q20r_q      <= ({1'b0, new_sum} >= {2'd0, len20});
      dvd_q       <= {new_sum, 1'b0} + {7'd0, new_pos};
      rem_q       <= '0;
      quo_q       <= '0;
    end
    if (state_q == StDiv) begin
      dvd_q <= {dvd_q[14:0], 1'b0};
      rem_q <= take ? 10'(trial - {1'b0, divisor}) : trial[9:0];
      quo_q <= {quo_q[14:0], take};
      if (div_cnt_q == 4'd15) begin
        mean_q <= ({quo_q[14:0], take} >= 16'(QualBins)) ? 7'(QualBins - 1)
                                                           : {quo_q[5:0], take};
      end
    end
    if (fin && !out_free) begin
      pend_value_q <= fin_value;
      pend_err_q   <= fin_err;
      pend_done_q  <= fin_done;
      pend_mean_q  <= fin_mean;
    end
    if (fin && out_free) begin
      out_value_q <= fin_value;
      out_err_q   <= fin_err;
      out_done_q  <= fin_done;
      out_mean_q  <= fin_mean;
    end else if ((state_q == StPush) && out_free) begin
      out_value_q <= pend_value_q;
      out_err_q   <= pend_err_q;
      out_done_q  <= pend_done_q;
      out_mean_q  <= pend_mean_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.value             = out_value_q;
  assign out_o.error             = out_err_q;
  assign out_o.read_done         = out_done_q;
  assign out_o.read_mean_quality = out_mean_q;

endmodule

// File: sv/rqsa_checker.sv
`include "read_quality_stats_accumulator_unit_defines.svh"

// Port-level checks on the result channel.
module rqsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_value,
  input logic [1:0]  out_error,
  input logic        out_read_done,
  input logic [6:0]  out_mean
);

  // A closed read comes from an accumulate word, which reports no value.
  `RQSA_ASSERT(a_done_no_value, out_valid && out_read_done |-> out_value == 48'd0)
  // The mean is reported only with a closed read.
  `RQSA_ASSERT(a_mean_only_done, out_valid && !out_read_done |-> out_mean == 7'd0)
  // The rounded mean stays within the histogram.
  `RQSA_ASSERT(a_mean_range, out_valid |-> out_mean < 7'd100)
  // A stalled word holds.
  `RQSA_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_value)
               && $stable(out_error))

endmodule

bind read_quality_stats_accumulator_unit rqsa_checker u_rqsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_value     (out_o.value),
  .out_error     (out_o.error),
  .out_read_done (out_o.read_done),
  .out_mean      (out_o.read_mean_quality)
);

// File: test/tb_rqsa_if.sv
`timescale 1ns / 1ps

// Testbench copies of the channel interfaces are not needed: the RTL
// interfaces are instantiated directly. This file holds the stimulus and result word types.
package tb_rqsa_types_pkg;

  // One input word as the testbench sees it.
  typedef struct packed {
    logic       func;
    logic [2:0] base_code;
    logic [6:0] quality;
    logic       is_reverse;
    logic       last_base;
    logic       skip_read;
    logic [2:0] table_sel;
    logic [8:0] index;
  } base_word_t;

  // One result word.
  typedef struct packed {
    logic [47:0] value;
    logic [1:0]  error;
    logic        read_done;
    logic [6:0]  read_mean_quality;
  } stat_word_t;

endpackage

// File: test/tb_read_quality_stats_accumulator_unit.sv
`timescale 1ns / 1ps

module tb_read_quality_stats_accumulator_unit;
  import rqsa_pkg::*;
  import tb_rqsa_types_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;

  rqsa_in_if  in_ch ();
  rqsa_out_if out_ch ();
  rqsa_cfg_if cfg_ch ();

  read_quality_stats_accumulator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Shadow copy of the statistics stores.
  logic [31:0] pos_counts [PbcDepth];
  logic [39:0] fwd_qsums [MaxReadLen];
  logic [39:0] rev_qsums [MaxReadLen];
  logic [47:0] base_qhist [QualBins];
  logic [31:0] read_qhist [QualBins];
  logic [31:0] len_hist [LenDepth];
  logic [47:0] totals [NumTotals];
  int unsigned open_len;
  int unsigned open_qsum;
  logic        long_mode;

  stat_word_t expected_stats [$];
  int          fail_count;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned reads_closed;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Clock and watchdog.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Works out the readout value for one table lookup.
  function automatic logic [48:0] lookup_stat(logic [2:0] sel, logic [2:0] base,
                                              logic [8:0] idx);
    case (sel)
      TblBaseCnt: if (base < NumBases && idx < MaxReadLen)
        return {1'b0, 16'd0, pos_counts[base * MaxReadLen + idx]};
      TblFwdQsum: if (idx < MaxReadLen) return {1'b0, 8'd0, fwd_qsums[idx]};
      TblRevQsum: if (idx < MaxReadLen) return {1'b0, 8'd0, rev_qsums[idx]};
      TblBaseQh:  if (idx < QualBins) return {1'b0, base_qhist[idx]};
      TblReadQh:  if (idx < QualBins) return {1'b0, 16'd0, read_qhist[idx]};
      TblTotals:  if (idx < NumTotals) return {1'b0, totals[idx]};
      TblLenHist: if (idx <= MaxReadLen) return {1'b0, 16'd0, len_hist[idx]};
      default: ;
    endcase
    return {1'b1, 48'd0};
  endfunction

  // Applies one accepted word to the shadow stores and returns its result.
  function automatic stat_word_t update_stats(base_word_t w);
    stat_word_t  r;
    logic [48:0] lk;
    logic        fwd;
    int unsigned b;
    int unsigned m;
    r = '0;
    fwd = long_mode || !w.is_reverse;
    if (w.func) begin
      lk = lookup_stat(w.table_sel, w.base_code, w.index);
      r.value = lk[47:0];
      r.error = lk[48] ? ErrRange : ErrNone;
    end else if (!w.skip_read) begin
      if (w.quality >= QualBins) begin
        r.error = ErrQual;
      end else begin
        totals[TotBases] += 1;
        if (w.quality >= 20) totals[TotQ20Bases] += 1;
        if (w.quality >= 30) totals[TotQ30Bases] += 1;
        base_qhist[w.quality] += 1;
        if (open_len < MaxReadLen) begin
          b = (w.base_code < NumBases) ? w.base_code : BaseN;
          pos_counts[b * MaxReadLen + open_len] += 1;
          if (fwd) fwd_qsums[open_len] += w.quality;
          else rev_qsums[open_len] += w.quality;
          open_qsum += w.quality;
          open_len++;
        end else begin
          r.error = ErrRange;
        end
      end
      if (w.last_base && open_len > 0) begin
        m = (2 * open_qsum + open_len) / (2 * open_len);
        if (m >= QualBins) m = QualBins - 1;
        totals[fwd ? TotFwdReads : TotRevReads] += 1;
        len_hist[open_len] += 1;
        read_qhist[m] += 1;
        if (open_qsum >= 20 * open_len) totals[TotQ20Reads] += 1;
        open_len = 0;
        open_qsum = 0;
        r.read_done = 1'b1;
        r.read_mean_quality = m[6:0];
        reads_closed++;
      end
    end
    return r;
  endfunction

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    stat_word_t got;
    stat_word_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.value, out_ch.error, out_ch.read_done, out_ch.read_mean_quality};
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        fail_count++;
      end else begin
        exp_w = expected_stats.pop_front();
        words_checked++;
        if (got.value !== exp_w.value)
          $display("%0t: value expected %0d actual %0d", $time, exp_w.value, got.value);
        if (got.error !== exp_w.error)
          $display("%0t: error expected %0d actual %0d", $time, exp_w.error, got.error);
        if (got.read_done !== exp_w.read_done)
          $display("%0t: read_done expected %0d actual %0d", $time,
                   exp_w.read_done, got.read_done);
        if (got.read_mean_quality !== exp_w.read_mean_quality)
          $display("%0t: mean expected %0d actual %0d", $time,
                   exp_w.read_mean_quality, got.read_mean_quality);
        if (got !== exp_w) fail_count++;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one word; optional typed-in result replaces the prediction.
  // Valid stays high after acceptance until the next word or an idle cycle.
  task automatic send_word(base_word_t w, bit has_fixed, stat_word_t fixed);
    stat_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.func, in_ch.base_code, in_ch.quality, in_ch.is_reverse, in_ch.last_base,
     in_ch.skip_read, in_ch.table_sel, in_ch.index} <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = update_stats(w);
    if (has_fixed && pred !== fixed) begin
      $display("%0t: directed row expected %h predictor %h", $time, fixed, pred);
      fail_count++;
    end
    expected_stats.push_back(has_fixed ? fixed : pred);
    words_sent++;
  endtask

  // Waits for every result with the input held idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    cfg_ch.valid <= 1'b1;
    cfg_ch.long_read_mode <= mode;
    do @(posedge clk_i); while (!cfg_ch.ready);
    long_mode = mode;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic base_word_t acc_word(logic [2:0] b, logic [6:0] q, logic rev,
                                          logic last, logic skip);
    return '{1'b0, b, q, rev, last, skip, 3'd0, 9'd0};
  endfunction

  function automatic base_word_t rd_word(logic [2:0] sel, logic [2:0] b, logic [8:0] idx);
    return '{1'b1, b, 7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), sel, idx};
  endfunction

  // Random word: mostly well-formed reads, some noise and readouts.
  function automatic base_word_t random_word(int unsigned read_len);
    base_word_t w;
    int unsigned pick;
    w = base_word_t'(26'($urandom));
    pick = $urandom_range(99);
    w.func = 1'b0;
    if (pick < 15) begin
      w.func = 1'b1;
      w.table_sel = 3'($urandom_range(7));
      w.index = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(7));
    end else if (pick < 80) begin
      w.skip_read = 1'b0;
      w.quality = 7'($urandom_range(QualBins - 1));
      w.last_base = ($urandom_range(read_len) == 0);
    end
    return w;
  endfunction

  typedef struct {
    base_word_t w;
    bit         has_fixed;
    stat_word_t fixed;
  } dir_row_t;

  initial begin
    dir_row_t    dir_rows [$];
    stat_word_t  ok0;
    int unsigned n;
    int unsigned rl;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.func, in_ch.base_code, in_ch.quality, in_ch.is_reverse, in_ch.last_base,
     in_ch.skip_read, in_ch.table_sel, in_ch.index} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.long_read_mode = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    words_sent = 0;
    words_checked = 0;
    reads_closed = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_mode = 1'b0;
    open_len = 0;
    open_qsum = 0;
    foreach (pos_counts[i]) pos_counts[i] = '0;
    foreach (fwd_qsums[i]) fwd_qsums[i] = '0;
    foreach (rev_qsums[i]) rev_qsums[i] = '0;
    foreach (base_qhist[i]) base_qhist[i] = '0;
    foreach (read_qhist[i]) read_qhist[i] = '0;
    foreach (len_hist[i]) len_hist[i] = '0;
    foreach (totals[i]) totals[i] = '0;
    ok0 = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: readouts after reset, extremes, errors and special cases.
    dir_rows.push_back('{rd_word(TblTotals, 3'd0, 9'd2), 1, ok0});
    dir_rows.push_back('{rd_word(TblLenHist, 3'd0, 9'd256), 1, ok0});
    dir_rows.push_back('{rd_word(TblLenHist, 3'd0, 9'd257), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{rd_word(3'd7, 3'd0, 9'd0), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{rd_word(TblBaseCnt, 3'd5, 9'd0), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{rd_word(TblBaseCnt, 3'd7, 9'd511), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{rd_word(TblTotals, 3'd0, 9'd6), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{rd_word(TblBaseQh, 3'd0, 9'd100), 1, '{48'd0, ErrRange, 1'b0, 7'd0}});
    dir_rows.push_back('{acc_word(3'd0, 7'd127, 1'b1, 1'b1, 1'b1), 1, ok0});
    dir_rows.push_back('{acc_word(3'd1, 7'd100, 1'b0, 1'b1, 1'b0),
                         1, '{48'd0, ErrQual, 1'b0, 7'd0}});
    dir_rows.push_back('{acc_word(3'd7, 7'd99, 1'b0, 1'b0, 1'b0), 1, ok0});
    dir_rows.push_back('{acc_word(3'd2, 7'd127, 1'b0, 1'b1, 1'b0),
                         1, '{48'd0, ErrQual, 1'b1, 7'd99}});
    dir_rows.push_back('{acc_word(3'd3, 7'd0, 1'b1, 1'b1, 1'b0), 1, '{48'd0, ErrNone, 1'b1, 7'd0}});
    dir_rows.push_back('{acc_word(3'd4, 7'd20, 1'b1, 1'b0, 1'b0), 0, ok0});
    dir_rows.push_back('{acc_word(3'd5, 7'd30, 1'b0, 1'b0, 1'b0), 0, ok0});
    dir_rows.push_back('{acc_word(3'd6, 7'd19, 1'b1, 1'b1, 1'b0), 0, ok0});
    for (int t = 0; t < 7; t++) dir_rows.push_back('{rd_word(3'(t), 3'd4, 9'd0), 0, ok0});
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_fixed, dir_rows[i].fixed);

    // One over-long read, closing into the top length bin.
    for (int i = 0; i < MaxReadLen + 3; i++)
      send_word(acc_word(3'($urandom), 7'($urandom_range(99)), 1'($urandom),
                         (i == MaxReadLen + 2), 1'b0), 0, ok0);
    send_word(rd_word(TblLenHist, 3'd0, 9'd256), 0, ok0);
    send_word(rd_word(TblFwdQsum, 3'd0, 9'd255), 0, ok0);
    send_word(rd_word(TblRevQsum, 3'd0, 9'd255), 0, ok0);

    // Random phases under different idling and register settings.
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      write_mode(ph[0]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      n = 0;
      while (n < 220) begin
        rl = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 8);
        send_word(random_word(rl), 0, ok0);
        n++;
        if (n == 110 && ph == 2) drain_results();
      end
      for (int t = 0; t < 8; t++)
        send_word(rd_word(TblTotals, 3'd0, 9'(t % NumTotals)), 0, ok0);
    end

    drain_results();
    $display("Checked %0d of %0d words, %0d reads closed, both strand modes.",
             words_checked, words_sent, reads_closed);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
